// ===== rtl/gni_pkg.sv =====
// ----------------------------------------------------------------------------
// gni_pkg
// Shared types and codes for the grid neighbour index unit: geometry and
// direction codes, the configuration bundle and the items between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package gni_pkg;

  // field widths
  localparam int unsigned REGION_W = 16;
  localparam int unsigned DIR_W    = 16;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned EDGE_W   = 9;
  localparam int unsigned COORD_W  = 8;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CIDX_W   = 2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_GEOMETRY_MODE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_REGION_COUNT  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_GRID_EDGE     = 2'd2;

  // geometry codes
  localparam logic [MODE_W-1:0] GEO_HEXAGON = 3'd0;
  localparam logic [MODE_W-1:0] GEO_SQUARE  = 3'd1;
  localparam logic [MODE_W-1:0] GEO_TORUS   = 3'd2;
  localparam logic [MODE_W-1:0] GEO_GRAPH   = 3'd3;
  localparam logic [MODE_W-1:0] GEO_RING    = 3'd4;
  localparam logic [MODE_W-1:0] GEO_BIDRING = 3'd5;
  localparam logic [MODE_W-1:0] GEO_STAR    = 3'd6;
  // geometry code with no layout behind it
  localparam logic [MODE_W-1:0] GEO_UNUSED  = 3'd7;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_N  = 16'd0;
  localparam logic [DIR_W-1:0] DIR_S  = 16'd1;
  localparam logic [DIR_W-1:0] DIR_E  = 16'd2;
  localparam logic [DIR_W-1:0] DIR_W_ = 16'd3;
  localparam logic [DIR_W-1:0] DIR_NE = 16'd4;
  localparam logic [DIR_W-1:0] DIR_NW = 16'd5;
  localparam logic [DIR_W-1:0] DIR_SE = 16'd6;
  localparam logic [DIR_W-1:0] DIR_SW = 16'd7;

  // configuration as seen by the pipeline
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] count;
    logic [EDGE_W-1:0]  grid_edge;
    logic [COUNT_W-1:0] grid_sq;
  } cfg_t;

  // item leaving the divider: row in quo, column in rem
  typedef struct packed {
    logic [REGION_W-1:0] from;
    logic [DIR_W-1:0]    dir;
    logic [REGION_W-1:0] rem;
    logic [COORD_W-1:0]  quo;
  } div_item_t;

  // item leaving the step stage
  typedef struct packed {
    logic                ok;
    logic                grid;
    logic [COORD_W-1:0]  nx;
    logic [COORD_W-1:0]  ny;
    logic [COUNT_W-1:0]  dres;
  } step_item_t;

endpackage

`default_nettype wire

// ===== rtl/grid_neighbour_index_unit.sv =====
// ----------------------------------------------------------------------------
// grid_neighbour_index_unit
// Gives the index of the region next to a start region in one direction, for
// hexagon, square, torus, graph, ring, bidirectional ring and star layouts.
//
//   channel  dir  signals                       contents
//   s_*      in   s_tvalid s_tready s_tdata     from_region, direction
//   m_*      out  m_tvalid m_tready m_tdata     neighbour, flag in m_tuser
//   cfg_*    in   cfg_we cfg_index cfg_wdata    geometry, count, grid edge
//
// One transaction per cycle while the output is not stalled; each passes four
// divider stages (two row bits each), the step stage, the index rebuild
// multiply and the range check into the output register.
// rst clears the valid bits and returns the configuration registers to reset.
// A stage holds when the one after it is full and stalled; bubbles close up,
// so input is taken while a finished result waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_neighbour_index_unit
  import gni_pkg::*;
#(
  parameter int unsigned REGION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // slave side
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [31:0]        s_tdata,   // [15:0] from_region, [31:16] direction
  // master side
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [15:0]             m_tdata,   // [15:0] neighbour
  output logic [0:0]              m_tuser,   // [0] neighbour_valid
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [COUNT_W-1:0] cfg_wdata
);

  logic [MODE_W-1:0]  geometry_mode;
  logic [COUNT_W-1:0] region_count;
  logic [EDGE_W-1:0]  grid_edge;
  logic [COUNT_W-1:0] grid_sq;
  cfg_t               cfg;

  logic       div_valid;
  logic       div_ready;
  div_item_t  div_item;
  logic       step_valid;
  logic       step_ready;
  step_item_t step_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      geometry_mode <= GEO_HEXAGON;
      region_count  <= COUNT_W'(1);
      grid_edge     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GEOMETRY_MODE: geometry_mode <= cfg_wdata[MODE_W-1:0];
        CFG_REGION_COUNT:  region_count  <= cfg_wdata;
        CFG_GRID_EDGE:     grid_edge     <= cfg_wdata[EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  // squared edge, bound for the start row check
  always_ff @(posedge clk) begin
    grid_sq <= COUNT_W'(grid_edge * grid_edge);
  end

  assign cfg = '{mode: geometry_mode, count: region_count,
                 grid_edge: grid_edge, grid_sq: grid_sq};

  gni_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_from   (s_tdata[15:0]),
    .in_dir    (s_tdata[31:16]),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_item  (div_item)
  );

  gni_step u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_item   (div_item),
    .out_valid (step_valid),
    .out_ready (step_ready),
    .out_item  (step_item)
  );

  gni_join #(
    .REGION_BITS (REGION_BITS)
  ) u_join (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (step_valid),
    .in_ready        (step_ready),
    .in_item         (step_item),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .neighbour       (m_tdata),
    .neighbour_valid (m_tuser[0])
  );

  // an invalid result carries index zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("invalid neighbour with non-zero index");

  // a valid neighbour lies inside the topology
  a_valid_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> {1'b0, m_tdata} < region_count)
    else $error("neighbour outside region count");

  // input is only refused when the whole pipeline is full and stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input refused without output stall");

  // the unused geometry code never yields a neighbour
  a_unused_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && geometry_mode == GEO_UNUSED |-> !m_tuser[0])
    else $error("neighbour from unused geometry");

endmodule

`default_nettype wire

// ===== rtl/gni_divider.sv =====
// ----------------------------------------------------------------------------
// gni_divider
// Pipelined restoring divider: splits the region index into row and column
// by the grid edge, two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gni_divider
  import gni_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [REGION_W-1:0] in_from,
  input  wire logic [DIR_W-1:0]    in_dir,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output div_item_t                out_item
);

  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned STAGES         = COORD_W / BITS_PER_STAGE;
  localparam int unsigned QBIT_W         = $clog2(COORD_W);

  logic [STAGES-1:0] v;
  logic [STAGES:0]   rdy;
  logic [STAGES-1:0] src_v;
  div_item_t         st  [STAGES];
  div_item_t         src [STAGES];
  div_item_t         nxt [STAGES];

  assign rdy[STAGES] = out_ready;
  assign in_ready    = rdy[0];
  assign out_valid   = v[STAGES-1];
  assign out_item    = st[STAGES-1];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    // stage source: the input port or the previous stage
    if (k == 0) begin : g_first
      assign src_v[k] = in_valid;
      assign src[k]   = '{from: in_from, dir: in_dir, rem: in_from, quo: '0};
    end else begin : g_next
      assign src_v[k] = v[k-1];
      assign src[k]   = st[k-1];
    end

    assign rdy[k] = !v[k] || rdy[k+1];

    // trial subtraction for this stage's quotient bits
    always_comb begin
      logic [COUNT_W-1:0] trial;
      logic [COUNT_W-1:0] rem_x;
      logic [QBIT_W-1:0]  b;
      nxt[k] = src[k];
      for (int unsigned j = 0; j < BITS_PER_STAGE; j++) begin
        b     = QBIT_W'(COORD_W - 1 - k * BITS_PER_STAGE - j);
        trial = COUNT_W'(cfg.grid_edge) << b;
        rem_x = {1'b0, nxt[k].rem};
        if (rem_x >= trial) begin
          nxt[k].rem    = REGION_W'(rem_x - trial);
          nxt[k].quo[b] = 1'b1;
        end
      end
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= src_v[k];
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (rdy[k] && src_v[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gni_step.sv =====
// ----------------------------------------------------------------------------
// gni_step
// Moves one cell in the chosen direction on the grid (hexagon, square,
// torus) and works out the result of the index-based geometries.
// ----------------------------------------------------------------------------
`default_nettype none

module gni_step
  import gni_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire div_item_t in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output step_item_t     out_item
);

  localparam int unsigned S_W = COORD_W + 2;

  step_item_t nxt;
  logic       v;

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  // neighbour coordinates and direct results
  always_comb begin
    logic               in_topo;
    logic               grid_pre;
    logic               dir_ok;
    logic               odd;
    logic [COUNT_W-1:0] from_x;
    logic signed [S_W-1:0] sx;
    logic signed [S_W-1:0] sy;
    logic signed [S_W-1:0] se;
    logic signed [S_W-1:0] hx;

    from_x   = {1'b0, in_item.from};
    in_topo  = from_x < cfg.count;
    grid_pre = in_topo && (cfg.grid_edge != '0) && (from_x < cfg.grid_sq);
    odd      = in_item.quo[0];
    sx       = signed'({2'b00, in_item.rem[COORD_W-1:0]});
    sy       = signed'({2'b00, in_item.quo});
    se       = signed'({1'b0, cfg.grid_edge});
    hx       = odd ? sx : sx - S_W'(1);
    dir_ok   = 1'b0;
    nxt      = '{ok: 1'b0, grid: 1'b0, nx: '0, ny: '0, dres: '0};

    unique case (cfg.mode)
      GEO_HEXAGON: begin
        nxt.grid = 1'b1;
        dir_ok   = 1'b1;
        unique case (in_item.dir)
          DIR_NW: begin sx = hx;          sy = sy - S_W'(1); end
          DIR_NE: begin sx = hx + S_W'(1); sy = sy - S_W'(1); end
          DIR_SW: begin sx = hx;          sy = sy + S_W'(1); end
          DIR_SE: begin sx = hx + S_W'(1); sy = sy + S_W'(1); end
          DIR_E:  sx = sx + S_W'(1);
          DIR_W_: sx = sx - S_W'(1);
          default: dir_ok = 1'b0;
        endcase
      end
      GEO_SQUARE, GEO_TORUS: begin
        nxt.grid = 1'b1;
        dir_ok   = 1'b1;
        unique case (in_item.dir)
          DIR_N:  sy = sy - S_W'(1);
          DIR_S:  sy = sy + S_W'(1);
          DIR_E:  sx = sx + S_W'(1);
          DIR_W_: sx = sx - S_W'(1);
          default: dir_ok = 1'b0;
        endcase
        // torus wraps at the edges
        if (cfg.mode == GEO_TORUS) begin
          if (sy < 0)   sy = se - S_W'(1);
          if (sy >= se) sy = '0;
          if (sx < 0)   sx = se - S_W'(1);
          if (sx >= se) sx = '0;
        end
      end
      GEO_GRAPH: begin
        nxt.dres = {1'b0, in_item.dir};
        nxt.ok   = in_topo;
      end
      GEO_RING, GEO_BIDRING: begin
        if (in_item.dir == DIR_E) begin
          nxt.dres = (from_x + COUNT_W'(1) == cfg.count) ? '0 : from_x + COUNT_W'(1);
          nxt.ok   = in_topo;
        end else if (in_item.dir == DIR_W_ && cfg.mode == GEO_BIDRING) begin
          nxt.dres = (in_item.from == '0) ? cfg.count - COUNT_W'(1)
                                          : from_x - COUNT_W'(1);
          nxt.ok   = in_topo;
        end
      end
      GEO_STAR: begin
        if (in_item.from != '0) begin
          nxt.dres = '0;
          nxt.ok   = in_topo && (in_item.dir == DIR_N);
        end else begin
          nxt.dres = {1'b0, in_item.dir} + COUNT_W'(1);
          nxt.ok   = in_topo;
        end
      end
      default: nxt.ok = 1'b0;
    endcase

    // grid result only when inside the grid after the move
    if (nxt.grid) begin
      nxt.ok = grid_pre && dir_ok && (sx >= 0) && (sx < se) && (sy >= 0) && (sy < se);
      nxt.nx = sx[COORD_W-1:0];
      nxt.ny = sy[COORD_W-1:0];
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gni_join.sv =====
// ----------------------------------------------------------------------------
// gni_join
// Rebuilds the region index from row and column for the grid geometries,
// takes the direct result for the others, then checks it against the region
// count and the index limits; the last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gni_join
  import gni_pkg::*;
#(
  parameter int unsigned REGION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire step_item_t           in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [REGION_W-1:0]       neighbour,
  output logic                      neighbour_valid
);

  localparam logic [COUNT_W-1:0] REGION_LIMIT = (REGION_BITS >= COUNT_W) ? '1 :
      COUNT_W'((64'd1 << REGION_BITS) - 64'd1);
  localparam logic [COUNT_W-1:0] OUT_LIMIT = COUNT_W'((64'd1 << REGION_W) - 64'd1);

  logic               v1;
  logic               v2;
  logic               rdy1;
  logic               rdy2;
  logic               ok1;
  logic [COUNT_W-1:0] res1;
  logic [COUNT_W-1:0] res_next;
  logic               ok_next;

  assign rdy2      = !v2 || out_ready;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v2;

  // row times edge plus column
  assign res_next = in_item.grid
      ? COUNT_W'(in_item.ny * cfg.grid_edge) + COUNT_W'(in_item.nx)
      : in_item.dres;

  // range checks on the rebuilt index
  assign ok_next = ok1 && (res1 < cfg.count) && (res1 <= REGION_LIMIT) && (res1 <= OUT_LIMIT);

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      ok1  <= in_item.ok;
      res1 <= res_next;
    end
    if (rdy2 && v1) begin
      neighbour_valid <= ok_next;
      neighbour       <= ok_next ? res1[REGION_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

// ===== verif/grid_neighbour_index_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_neighbour_index_unit_tb
// Self-checking bench for the neighbour index unit. Each geometry is run under
// several region counts and grid edges, the extremes among them. The phases
// after reset feed random lookups, some after a few hand-picked ones. Both
// stream sides idle at random. Each accepted lookup is predicted here, and
// every output transaction is checked in order against that prediction.
// ----------------------------------------------------------------------------

module grid_neighbour_index_unit_tb;
  import gni_pkg::*;

  localparam longint REGION_MAX = 65535;

  typedef struct {
    logic [31:0] query;
    logic [15:0] neighbour;
    logic        found;
  } neighbour_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [31:0]        s_tdata = '0;   // [15:0] from_region, [31:16] direction
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [15:0]        m_tdata;        // [15:0] neighbour
  logic [0:0]         m_tuser;        // [0] neighbour_valid
  logic               cfg_we = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [COUNT_W-1:0] cfg_wdata = '0;

  // bench copy of the configuration, reset values
  logic [MODE_W-1:0]  geo_mode = GEO_HEXAGON;
  int unsigned        region_count = 1;
  int unsigned        grid_edge_len = 0;

  logic [31:0]        query_q[$];
  neighbour_t         neighbour_q[$];
  bit                 in_accepted = 1'b0;
  bit                 out_accepted = 1'b0;
  bit                 sender_idles = 1'b1;
  bit                 receiver_idles = 1'b1;
  int unsigned        send_gap = 0;
  int unsigned        hold_left = 0;
  int unsigned        err_count = 0;

  grid_neighbour_index_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // neighbour of one region under the current configuration
  function automatic void predict_neighbour(input logic [15:0] from, input logic [15:0] dir,
                                            output logic [15:0] nb, output logic found);
    longint cnt, e, x, y, odd, res;
    bit     hit;
    cnt = region_count;
    e   = grid_edge_len;
    res = 0;
    hit = 1'b0;
    if (longint'(from) < cnt) begin
      case (geo_mode)
        GEO_HEXAGON, GEO_SQUARE, GEO_TORUS: begin
          if (e != 0) begin
            y = longint'(from) / e;
            x = longint'(from) - y * e;
            if (y < e) begin
              odd = y & 1;
              hit = 1'b1;
              if (geo_mode == GEO_HEXAGON) begin
                // odd rows sit half a cell to the right
                case (dir)
                  DIR_NW:  begin x += odd - 1; y -= 1; end
                  DIR_NE:  begin x += odd;     y -= 1; end
                  DIR_SW:  begin x += odd - 1; y += 1; end
                  DIR_SE:  begin x += odd;     y += 1; end
                  DIR_E:   x += 1;
                  DIR_W_:  x -= 1;
                  default: hit = 1'b0;
                endcase
              end else begin
                case (dir)
                  DIR_N:   y -= 1;
                  DIR_S:   y += 1;
                  DIR_E:   x += 1;
                  DIR_W_:  x -= 1;
                  default: hit = 1'b0;
                endcase
                // torus wraps to the opposite edge
                if (geo_mode == GEO_TORUS) begin
                  if (y < 0) y = e - 1;
                  if (y >= e) y = 0;
                  if (x < 0) x = e - 1;
                  if (x >= e) x = 0;
                end
              end
              if (x < 0 || x >= e || y < 0 || y >= e) hit = 1'b0;
              res = y * e + x;
            end
          end
        end
        GEO_GRAPH: begin
          res = dir;
          hit = 1'b1;
        end
        GEO_RING, GEO_BIDRING: begin
          if (dir == DIR_E) begin
            res = (longint'(from) + 1 == cnt) ? 0 : longint'(from) + 1;
            hit = 1'b1;
          end else if (dir == DIR_W_ && geo_mode == GEO_BIDRING) begin
            res = (from == 0) ? cnt - 1 : longint'(from) - 1;
            hit = 1'b1;
          end
        end
        GEO_STAR: begin
          // leaves only reach the hub, the hub reaches leaf dir + 1
          if (from != 0) begin
            if (dir == DIR_N) begin
              res = 0;
              hit = 1'b1;
            end
          end else begin
            res = longint'(dir) + 1;
            hit = 1'b1;
          end
        end
        default: hit = 1'b0;
      endcase
    end
    // result must be a region and fit the index
    if (hit && (res < 0 || res >= cnt || res > REGION_MAX)) hit = 1'b0;
    nb    = hit ? 16'(res) : '0;
    found = hit;
  endfunction

  // random lookup shaped for the current geometry
  function automatic logic [31:0] pick_query();
    int unsigned lim, e, r, y, x;
    logic [15:0] f, d;
    lim = region_count - 1;
    e   = grid_edge_len;
    r   = $urandom_range(0, 99);
    if (r < 8) begin
      f = 16'($urandom);
    end else if (r < 16) begin
      case ($urandom_range(0, 3))
        0:       f = '0;
        1:       f = 16'(lim);
        2:       f = 16'(lim + 1);
        default: f = '1;
      endcase
    end else if (geo_mode <= GEO_TORUS && e != 0) begin
      y = $urandom_range(0, e - 1);
      x = $urandom_range(0, e - 1);
      // lean on the border rows and columns
      if (r < 40) y = r[0] ? 0 : e - 1;
      else if (r < 60) x = r[0] ? 0 : e - 1;
      f = 16'(y * e + x);
    end else if (geo_mode == GEO_STAR && r < 50) begin
      f = '0;
    end else begin
      f = 16'($urandom_range(0, lim));
    end

    r = $urandom_range(0, 99);
    if (r < 8) begin
      d = 16'($urandom);
    end else begin
      case (geo_mode)
        GEO_GRAPH, GEO_STAR: begin
          if (geo_mode == GEO_STAR && f != 0) begin
            d = (r < 70) ? DIR_N : 16'($urandom_range(1, 9));
          end else if (r < 25) begin
            case ($urandom_range(0, 3))
              0:       d = 16'(lim);
              1:       d = 16'(lim - 1);
              2:       d = 16'(lim + 1);
              default: d = '1;
            endcase
          end else begin
            d = 16'($urandom_range(0, lim));
          end
        end
        GEO_RING, GEO_BIDRING:
          d = (r < 80) ? (r[0] ? DIR_E : DIR_W_) : 16'($urandom_range(0, 7));
        default:
          d = (r < 95) ? 16'($urandom_range(0, 7)) : 16'($urandom_range(8, 15));
      endcase
    end
    return {d, f};
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 50) $display("%0t ns: %s", $time, what);
  endtask

  task automatic add_query(input logic [15:0] from, input logic [15:0] dir);
    query_q.push_back({dir, from});
  endtask

  task automatic add_random(input int unsigned n);
    repeat (n) query_q.push_back(pick_query());
  endtask

  // idle once nothing is queued, on the bus or still owed
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (query_q.size() != 0 || s_tvalid || neighbour_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= COUNT_W'(value);
    case (idx)
      CFG_GEOMETRY_MODE: geo_mode      = MODE_W'(value);
      CFG_REGION_COUNT:  region_count  = value & 32'h1FFFF;
      CFG_GRID_EDGE:     grid_edge_len = value & 32'h1FF;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode, input int unsigned count,
                           input int unsigned edge_len);
    wait_idle();
    write_reg(CFG_GEOMETRY_MODE, mode);
    write_reg(CFG_REGION_COUNT, count);
    write_reg(CFG_GRID_EDGE, edge_len);
    @(negedge clk);
    cfg_we <= 1'b0;
    sender_idles   = ($urandom_range(0, 3) != 0);
    receiver_idles = ($urandom_range(0, 3) != 0);
    @(posedge clk);
  endtask

  // monitor: prediction on input transactions, checks on output transactions
  always @(posedge clk) begin : monitor
    neighbour_t want;
    logic [15:0] nb;
    logic        found;
    in_accepted  = !rst && s_tvalid && s_tready;
    out_accepted = !rst && m_tvalid && m_tready;
    if (in_accepted) begin
      predict_neighbour(s_tdata[15:0], s_tdata[31:16], nb, found);
      want.query     = s_tdata;
      want.neighbour = nb;
      want.found     = found;
      neighbour_q.push_back(want);
    end
    if (out_accepted) begin
      if (neighbour_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result neighbour %0d flag %0b",
                                  m_tdata, m_tuser[0]));
      end else begin
        want = neighbour_q.pop_front();
        if (m_tdata !== want.neighbour)
          report_mismatch($sformatf("from %0d dir %0d mode %0d: neighbour %0d, want %0d",
                                    want.query[15:0], want.query[31:16], geo_mode,
                                    m_tdata, want.neighbour));
        if (m_tuser[0] !== want.found)
          report_mismatch($sformatf("from %0d dir %0d mode %0d: flag %0b, want %0b",
                                    want.query[15:0], want.query[31:16], geo_mode,
                                    m_tuser[0], want.found));
      end
    end
  end

  // lookup driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_accepted) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (query_q.size() != 0) begin
        s_tdata  <= query_q.pop_front();
        s_tvalid <= 1'b1;
        send_gap = sender_idles ? $urandom_range(0, 9) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_accepted) hold_left = receiver_idles ? $urandom_range(0, 9) : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: empty grid, start inside and outside the topology
    add_query(16'd0, DIR_E);
    add_query(16'hFFFF, DIR_N);

    // hexagon: every direction from an odd row, some from even rows, grid edges
    configure(GEO_HEXAGON, 16, 4);
    add_query(16'd5, DIR_NE);
    add_query(16'd5, DIR_NW);
    add_query(16'd5, DIR_SE);
    add_query(16'd5, DIR_SW);
    add_query(16'd5, DIR_E);
    add_query(16'd5, DIR_W_);
    add_query(16'd5, DIR_N);
    add_query(16'd5, DIR_S);
    add_query(16'd4, DIR_NW);
    add_query(16'd8, DIR_NW);
    add_query(16'd3, DIR_E);
    add_query(16'd16, DIR_E);
    add_query(16'd6, 16'hFFFF);
    add_random(80);
    configure(GEO_HEXAGON, 65536, 256);
    add_random(120);
    configure(GEO_HEXAGON, 30, 6);
    add_random(80);
    configure(GEO_HEXAGON, 100, 1);
    add_random(40);
    configure(GEO_HEXAGON, 200, 15);
    add_random(80);

    // square: moves off the grid are dropped
    configure(GEO_SQUARE, 9, 3);
    add_query(16'd0, DIR_N);
    add_query(16'd8, DIR_S);
    add_query(16'd4, DIR_E);
    add_random(80);
    configure(GEO_SQUARE, 65536, 256);
    add_random(120);
    configure(GEO_SQUARE, 50, 7);
    add_random(80);
    configure(GEO_SQUARE, 65536, 200);
    add_random(60);

    // torus: moves off an edge wrap
    configure(GEO_TORUS, 9, 3);
    add_query(16'd0, DIR_N);
    add_query(16'd0, DIR_W_);
    add_query(16'd8, DIR_S);
    add_query(16'd8, DIR_E);
    add_random(80);
    configure(GEO_TORUS, 65536, 256);
    add_random(120);
    configure(GEO_TORUS, 1, 1);
    add_random(30);
    configure(GEO_TORUS, 40, 0);
    add_random(30);
    configure(GEO_TORUS, 36, 6);
    add_random(80);

    // graph: direction is the index
    configure(GEO_GRAPH, 1000, 0);
    add_query(16'd3, 16'd999);
    add_query(16'd3, 16'd1000);
    add_random(80);
    configure(GEO_GRAPH, 1, 256);
    add_random(40);
    configure(GEO_GRAPH, 65536, 0);
    add_random(80);

    // rings
    configure(GEO_RING, 1, 0);
    add_random(30);
    configure(GEO_RING, 65536, 256);
    add_random(80);
    configure(GEO_RING, 7, 3);
    add_random(60);
    configure(GEO_BIDRING, 1, 0);
    add_random(30);
    configure(GEO_BIDRING, 65536, 0);
    add_random(80);
    configure(GEO_BIDRING, 5, 2);
    add_random(60);

    // star: hub and leaves
    configure(GEO_STAR, 1, 0);
    add_random(30);
    configure(GEO_STAR, 65536, 256);
    add_random(80);
    configure(GEO_STAR, 10, 0);
    add_random(60);

    // unused geometry code never finds a neighbour
    configure(GEO_UNUSED, 100, 10);
    add_random(40);

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
